// ----- rtl/whpu_pkg.sv -----
package whpu_pkg;

   localparam int MAX_BINS_DEF        = 64;
   localparam int BIN_COUNT_WIDTH_DEF = 32;
   localparam int RESULT_CAP          = 64;
   localparam int BIN_IDX_W           = 6;
   localparam int QUEUE_DEPTH         = 4;
   localparam int QAW                 = $clog2(QUEUE_DEPTH);
   localparam int MASS_W              = 40;
   localparam int CTOT_W              = 38;
   localparam int MTOT_W              = 46;
   localparam int BW_W                = 16;
   localparam int CSR_IDX_W           = 3;
   localparam int CSR_DATA_W          = 16;
   localparam int BCNT_W              = 7;

   localparam logic [1:0] KIND_ATOM  = 2'd0;
   localparam logic [1:0] KIND_FRAME = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [7:0] TYPE_HEAVY  = 8'd8;
   localparam logic [7:0] TYPE_LIGHT  = 8'd7;
   localparam logic [7:0] TYPE_MARKER = 8'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_WIDTH     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_BIN_WIDTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_COUNT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAVY_WEIGHT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_WEIGHT  = 3'd5;

   localparam logic [15:0] RST_RANGE_MIN     = 16'hFAE6;   // -1306
   localparam logic [15:0] RST_BIN_WIDTH     = 16'd52;
   localparam logic [15:0] RST_INV_BIN_WIDTH = 16'd1255;
   localparam logic [6:0]  RST_BIN_COUNT     = 7'd50;
   localparam logic [7:0]  RST_HEAVY_WEIGHT  = 8'd16;
   localparam logic [7:0]  RST_LIGHT_WEIGHT  = 8'd1;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         atom_type;
      logic signed [15:0] z_pos;
   } req_type;

   typedef struct packed {
      logic [5:0]         bin_index;
      logic signed [15:0] bin_center;
      logic [31:0]        count_density;
      logic [31:0]        mass_density;
      logic [31:0]        marked_frames;
      logic [31:0]        marker_runs;
      logic [31:0]        rejected_samples;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] range_min;
      logic [15:0]        bin_width;
      logic [15:0]        inv_bin_width;
      logic [6:0]         bin_count;
      logic [7:0]         heavy_weight;
      logic [7:0]         light_weight;
   } cfg_type;

   typedef enum logic [2:0] {
      OP_HEAVY,
      OP_LIGHT,
      OP_REJECT,
      OP_MARK,
      OP_FRAME,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [BIN_IDX_W-1:0]   bin;
      logic [7:0]             weight;
   } qent_type;

endpackage

// ----- rtl/weighted_position_histogram_unit.sv -----
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_stall | req_type: kind, atom_type, z_pos
// rsp     | out       | rsp_valid/rsp_stall | rsp_type: one bin of a readout
// csr     | in        | csr_wr_en           | csr_index, csr_wr_data (16 bits)
//
// Front takes one request a cycle into a 4-deep op queue; req_stall only when full.
// Back: atom record is bin RAM read, then write; marker, reject, frame done in idle.
// Readout: serial shift-add for the divisor products, then each bin is divided
// by the 32-step serial density dividers; rsp stalls hold the sequencer.
// Reset (synchronous) clears the bin valid bits at once, so the stores read zero.
module weighted_position_histogram_unit
   import whpu_pkg::*;
#(
   parameter int MAX_BINS        = MAX_BINS_DEF,
   parameter int BIN_COUNT_WIDTH = BIN_COUNT_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   // bins are capped at the readout length
   localparam int DEPTH = (MAX_BINS < RESULT_CAP) ? MAX_BINS : RESULT_CAP;

   cfg_type    cfg_ff;
   logic [6:0] act_bins;
   logic       q_valid;
   qent_type   q_data;
   logic       q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_min     <= RST_RANGE_MIN;
         cfg_ff.bin_width     <= RST_BIN_WIDTH;
         cfg_ff.inv_bin_width <= RST_INV_BIN_WIDTH;
         cfg_ff.bin_count     <= RST_BIN_COUNT;
         cfg_ff.heavy_weight  <= RST_HEAVY_WEIGHT;
         cfg_ff.light_weight  <= RST_LIGHT_WEIGHT;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RANGE_MIN:     cfg_ff.range_min     <= csr_wr_data;
            CSR_BIN_WIDTH:     cfg_ff.bin_width     <= csr_wr_data;
            CSR_INV_BIN_WIDTH: cfg_ff.inv_bin_width <= csr_wr_data;
            CSR_BIN_COUNT:     cfg_ff.bin_count     <= csr_wr_data[6:0];
            CSR_HEAVY_WEIGHT:  cfg_ff.heavy_weight  <= csr_wr_data[7:0];
            CSR_LIGHT_WEIGHT:  cfg_ff.light_weight  <= csr_wr_data[7:0];
            default:           cfg_ff               <= cfg_ff;
         endcase
      end
   end

   assign act_bins = (cfg_ff.bin_count > 7'(DEPTH)) ? 7'(DEPTH) : cfg_ff.bin_count;

   whpu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .act_bins  (act_bins),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop)
   );

   whpu_back #(
      .MAX_BINS        (MAX_BINS),
      .BIN_COUNT_WIDTH (BIN_COUNT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .act_bins  (act_bins),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // final bin of a readout is the last active bin
   a_last_bin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> rsp_data.bin_index == 6'(act_bins - 7'd1))
      else $error("last flag on wrong bin");

   // every run start is also a marked frame
   a_runs_le_frames: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.marker_runs <= rsp_data.marked_frames)
      else $error("marker runs exceed marked frames");

endmodule

// ----- rtl/whpu_ram.sv -----
module whpu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/whpu_dens.sv -----
// restoring divider: floor(sum * 2^23 / divisor), saturated to 32 bits; zero divisor gives zero
module whpu_dens #(
   parameter int SUM_W = 33,
   parameter int DIV_W = 54
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] sum,
   input  logic [DIV_W-1:0] divisor,
   output logic             busy,
   output logic [31:0]      result
);

   localparam int CW = (SUM_W > DIV_W + 9) ? SUM_W : DIV_W + 9;

   logic             busy_ff;
   logic [4:0]       cnt_ff;
   logic [DIV_W-1:0] r_ff;
   logic [DIV_W-1:0] d_ff;
   logic [31:0]      xs_ff;
   logic [31:0]      q_ff;

   logic [DIV_W:0]   r_sh;
   logic             ge;
   logic [DIV_W:0]   r_sub;

   always_comb begin
      r_sh  = {r_ff, xs_ff[31]};
      ge    = r_sh >= {1'b0, d_ff};
      r_sub = r_sh - {1'b0, d_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         cnt_ff <= '0;
         if (divisor == '0) begin
            q_ff <= '0;
         end else if (CW'(sum) >= (CW'(divisor) << 9)) begin
            q_ff <= '1;
         end else begin
            busy_ff <= 1'b1;
            r_ff    <= DIV_W'(sum >> 9);
            xs_ff   <= {sum[8:0], 23'd0};
            d_ff    <= divisor;
         end
      end else if (busy_ff) begin
         r_ff   <= ge ? r_sub[DIV_W-1:0] : r_sh[DIV_W-1:0];
         q_ff   <= {q_ff[30:0], ge};
         xs_ff  <= {xs_ff[30:0], 1'b0};
         cnt_ff <= cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy   = busy_ff;
   assign result = q_ff;

endmodule

// ----- rtl/whpu_front.sv -----
// request decode, bin selection and the op queue towards the back end
module whpu_front
   import whpu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic [6:0] act_bins,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   output logic     q_valid,
   output qent_type q_data,
   input  logic     q_pop
);

   qent_type         ent_ff [QUEUE_DEPTH];
   logic [QAW-1:0]   wr_ptr_ff;
   logic [QAW-1:0]   rd_ptr_ff;
   logic [QAW:0]     cnt_ff;

   logic signed [16:0] diff;
   logic [31:0]        prod;
   logic               in_range;
   logic               push;
   qent_type           ent;

   always_comb begin
      diff     = {req_data.z_pos[15], req_data.z_pos} - {cfg.range_min[15], cfg.range_min};
      prod     = 32'(diff[15:0]) * 32'(cfg.inv_bin_width);
      in_range = !diff[16] && (16'(act_bins) > prod[31:16]);
      push     = 1'b0;
      ent.op     = OP_FRAME;
      ent.bin    = prod[16 +: BIN_IDX_W];
      ent.weight = cfg.heavy_weight;
      case (req_data.kind)
         KIND_ATOM: begin
            if (req_data.atom_type == TYPE_HEAVY) begin
               push   = 1'b1;
               ent.op = in_range ? OP_HEAVY : OP_REJECT;
            end else if (req_data.atom_type == TYPE_LIGHT) begin
               push       = 1'b1;
               ent.op     = in_range ? OP_LIGHT : OP_REJECT;
               ent.weight = cfg.light_weight;
            end else if (req_data.atom_type == TYPE_MARKER) begin
               push   = 1'b1;
               ent.op = OP_MARK;
            end
         end
         KIND_FRAME: begin
            push   = 1'b1;
            ent.op = OP_FRAME;
         end
         KIND_READ: begin
            push   = 1'b1;
            ent.op = OP_READ;
         end
         default: begin
            push = 1'b0;
         end
      endcase
      push = push && req_valid && !req_stall;
   end

   assign req_stall = cnt_ff == (QAW+1)'(QUEUE_DEPTH);
   assign q_valid   = cnt_ff != '0;
   assign q_data    = ent_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= ent;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QAW'(1);
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QAW'(1);
         end
         cnt_ff <= cnt_ff + (QAW+1)'(push) - (QAW+1)'(q_pop);
      end
   end

endmodule

// ----- rtl/whpu_back.sv -----
// executes queued ops: bin read-modify-write, frame and reject counters, readout sequencer
module whpu_back
   import whpu_pkg::*;
#(
   parameter int MAX_BINS        = MAX_BINS_DEF,
   parameter int BIN_COUNT_WIDTH = BIN_COUNT_WIDTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic [6:0] act_bins,
   input  logic     q_valid,
   input  qent_type q_data,
   output logic     q_pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   localparam int DEPTH = (MAX_BINS < RESULT_CAP) ? MAX_BINS : RESULT_CAP;
   localparam int AW    = $clog2(DEPTH);
   localparam int BCW   = BIN_COUNT_WIDTH;
   localparam int DCW   = CTOT_W + BW_W;
   localparam int DMW   = MTOT_W + BW_W;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_UPD  = 8'b0000_0010,
      S_MUL  = 8'b0000_0100,
      S_RDI  = 8'b0000_1000,
      S_RDM  = 8'b0001_0000,
      S_SUM  = 8'b0010_0000,
      S_DIV  = 8'b0100_0000,
      S_OUT  = 8'b1000_0000
   } state_type;

   state_type          state_ff;
   qent_type           op_ff;
   logic [DEPTH-1:0]   vld_ff;
   logic               rd_vld_ff;
   logic [CTOT_W-1:0]  ctot_ff;
   logic [MTOT_W-1:0]  mtot_ff;
   logic               fmark_ff;
   logic               pmark_ff;
   logic [31:0]        mfc_ff;
   logic [31:0]        run_ff;
   logic [31:0]        rej_ff;
   logic [3:0]         mcnt_ff;
   logic [BW_W-1:0]    bw_sh_ff;
   logic [DCW-1:0]     ctot_sh_ff;
   logic [DMW-1:0]     mtot_sh_ff;
   logic [DCW-1:0]     dc_ff;
   logic [DMW-1:0]     dm_ff;
   logic [AW-1:0]      idx_ff;
   logic [BCW-1:0]     ci_ff;
   logic [MASS_W-1:0]  mi_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      mirror;
   logic [BCW-1:0]     ram_c_rd;
   logic [MASS_W-1:0]  ram_m_rd;
   logic [BCW-1:0]     cdat;
   logic [MASS_W-1:0]  mdat;
   logic               wr_en;
   logic [BCW-1:0]     new_c;
   logic [MASS_W-1:0]  new_m;
   logic [MASS_W:0]    msum;
   logic [MASS_W-1:0]  m_delta;
   logic [MTOT_W:0]    mtsum;
   logic               dens_start;
   logic [BCW:0]       sum_c;
   logic [MASS_W:0]    sum_m;
   logic               busy_c;
   logic               busy_m;
   logic [31:0]        dens_c;
   logic [31:0]        dens_m;
   logic               out_free;
   logic               is_last;
   logic [22:0]        cprod;
   logic signed [25:0] ctr_t;
   logic signed [25:0] ctr_c;
   logic [15:0]        ctr_sat;

   always_comb begin
      mirror = AW'(act_bins - 7'd1 - 7'(idx_ff));
      case (state_ff)
         S_IDLE:  rd_addr = q_data.bin[AW-1:0];
         S_RDM:   rd_addr = mirror;
         default: rd_addr = idx_ff;
      endcase
      cdat  = rd_vld_ff ? ram_c_rd : '0;
      mdat  = rd_vld_ff ? ram_m_rd : '0;
      wr_en = state_ff == S_UPD;

      // saturating bin updates; totals take only what the bin really gained
      new_c   = (op_ff.op == OP_HEAVY && cdat != '1) ? cdat + BCW'(1) : cdat;
      msum    = {1'b0, mdat} + (MASS_W+1)'(op_ff.weight);
      new_m   = msum[MASS_W] ? '1 : msum[MASS_W-1:0];
      m_delta = new_m - mdat;
      mtsum   = {1'b0, mtot_ff} + (MTOT_W+1)'(m_delta);

      dens_start = state_ff == S_SUM;
      sum_c      = {1'b0, ci_ff} + {1'b0, cdat};
      sum_m      = {1'b0, mi_ff} + {1'b0, mdat};

      out_free = !rsp_valid_ff || !rsp_stall;
      is_last  = idx_ff == AW'(act_bins - 7'd1);

      // centre = floor((2*min + (2i+1)*width) / 2)
      cprod = 23'({idx_ff, 1'b1}) * 23'(cfg.bin_width);
      ctr_t = 26'(signed'({cfg.range_min, 1'b0})) + signed'(26'(cprod));
      ctr_c = ctr_t >>> 1;
      if (ctr_c > 26'sd32767) begin
         ctr_sat = 16'h7FFF;
      end else if (ctr_c < -26'sd32768) begin
         ctr_sat = 16'h8000;
      end else begin
         ctr_sat = ctr_c[15:0];
      end
      q_pop = state_ff == S_IDLE && q_valid;
   end

   whpu_ram #(.WIDTH(BCW), .DEPTH(DEPTH)) u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (op_ff.bin[AW-1:0]),
      .wr_data (new_c),
      .rd_addr (rd_addr),
      .rd_data (ram_c_rd)
   );

   whpu_ram #(.WIDTH(MASS_W), .DEPTH(DEPTH)) u_mass_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (op_ff.bin[AW-1:0]),
      .wr_data (new_m),
      .rd_addr (rd_addr),
      .rd_data (ram_m_rd)
   );

   whpu_dens #(.SUM_W(BCW + 1), .DIV_W(DCW)) u_count_dens (
      .clock   (clock),
      .reset   (reset),
      .start   (dens_start),
      .sum     (sum_c),
      .divisor (dc_ff),
      .busy    (busy_c),
      .result  (dens_c)
   );

   whpu_dens #(.SUM_W(MASS_W + 1), .DIV_W(DMW)) u_mass_dens (
      .clock   (clock),
      .reset   (reset),
      .start   (dens_start),
      .sum     (sum_m),
      .divisor (dm_ff),
      .busy    (busy_m),
      .result  (dens_m)
   );

   always_ff @(posedge clock) begin
      rd_vld_ff <= vld_ff[rd_addr];
      if (q_pop) begin
         op_ff <= q_data;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         vld_ff       <= '0;
         ctot_ff      <= '0;
         mtot_ff      <= '0;
         fmark_ff     <= 1'b0;
         pmark_ff     <= 1'b0;
         mfc_ff       <= '0;
         run_ff       <= '0;
         rej_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  case (q_data.op)
                     OP_HEAVY, OP_LIGHT: begin
                        state_ff <= S_UPD;
                     end
                     OP_REJECT: begin
                        rej_ff <= (rej_ff == '1) ? rej_ff : rej_ff + 32'd1;
                     end
                     OP_MARK: begin
                        fmark_ff <= 1'b1;
                     end
                     OP_FRAME: begin
                        if (fmark_ff) begin
                           mfc_ff <= (mfc_ff == '1) ? mfc_ff : mfc_ff + 32'd1;
                           if (!pmark_ff) begin
                              run_ff <= (run_ff == '1) ? run_ff : run_ff + 32'd1;
                           end
                        end
                        pmark_ff <= fmark_ff;
                        fmark_ff <= 1'b0;
                     end
                     OP_READ: begin
                        bw_sh_ff   <= cfg.bin_width;
                        ctot_sh_ff <= DCW'(ctot_ff);
                        mtot_sh_ff <= DMW'(mtot_ff);
                        dc_ff      <= '0;
                        dm_ff      <= '0;
                        mcnt_ff    <= '0;
                        idx_ff     <= '0;
                        state_ff   <= S_MUL;
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_UPD: begin
               vld_ff[op_ff.bin[AW-1:0]] <= 1'b1;
               if (new_c != cdat && ctot_ff != '1) begin
                  ctot_ff <= ctot_ff + CTOT_W'(1);
               end
               mtot_ff  <= mtsum[MTOT_W] ? '1 : mtsum[MTOT_W-1:0];
               state_ff <= S_IDLE;
            end
            S_MUL: begin
               // shift-add: divisor = total * bin_width, one bit a cycle
               if (bw_sh_ff[0]) begin
                  dc_ff <= dc_ff + ctot_sh_ff;
                  dm_ff <= dm_ff + mtot_sh_ff;
               end
               bw_sh_ff   <= bw_sh_ff >> 1;
               ctot_sh_ff <= ctot_sh_ff << 1;
               mtot_sh_ff <= mtot_sh_ff << 1;
               mcnt_ff    <= mcnt_ff + 4'd1;
               if (mcnt_ff == 4'd15) begin
                  state_ff <= (act_bins == 7'd0) ? S_IDLE : S_RDI;
               end
            end
            S_RDI: begin
               state_ff <= S_RDM;
            end
            S_RDM: begin
               ci_ff    <= cdat;
               mi_ff    <= mdat;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (!busy_c && !busy_m) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff            <= 1'b1;
                  rsp_ff.bin_index        <= 6'(idx_ff);
                  rsp_ff.bin_center       <= ctr_sat;
                  rsp_ff.count_density    <= dens_c;
                  rsp_ff.mass_density     <= dens_m;
                  rsp_ff.marked_frames    <= mfc_ff;
                  rsp_ff.marker_runs      <= run_ff;
                  rsp_ff.rejected_samples <= rej_ff;
                  rsp_ff.last             <= is_last;
                  if (is_last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + AW'(1);
                     state_ff <= S_RDI;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
